// ===== hdl/shb_pkg.sv =====
// Shared types, constants and the block multiply for the 256-bit block hash.
// Used by every module in this folder; depends on nothing.
package shb_pkg;

	// Stream widths: tdata carries block_low, block_high, valid_bytes (133 bits -> 17 bytes)
	localparam int unsigned S_TDATA_W   = 136;
	localparam int unsigned M_TDATA_W   = 256;
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned COUNT_W     = 5;

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Per-lane multiplier constants
	localparam logic [31:0] MUL_K0 = 32'h98B3_65A1;
	localparam logic [31:0] MUL_K1 = 32'h52C6_9CAB;
	localparam logic [31:0] MUL_K2 = 32'hB76A_9A41;
	localparam logic [31:0] MUL_K3 = 32'hCC4D_2C7B;

	// Initial lane pair of each 128-bit half
	localparam logic [63:0] INIT_LO = 64'hC726_5595_564A_4447;
	localparam logic [63:0] INIT_HI = 64'h128F_A608_E20C_241D;

	// Xor-shift distances within a 64-bit lane
	localparam int unsigned XS_FIRST  = 29;
	localparam int unsigned XS_SECOND = 21;

	// Four 64-bit lanes, lane 0 in the lowest bits
	typedef logic [3:0][63:0] lanes_t;
	// One 128-bit half: element 0 is the low lane
	typedef logic [1:0][63:0] half_t;

	localparam lanes_t INIT_LANES = {INIT_HI, INIT_LO, INIT_HI, INIT_LO};

	// One queue entry: products of a block plus its kind
	typedef struct packed {
		lanes_t prod;
		logic   has_block;
		logic   last;
	} qent_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_MIX,
		B_FMUL,
		B_EMIT
	} back_st_t;

	// Four 32x32 products of a block, one per state lane
	function automatic lanes_t mul_block(input logic [63:0] lo, input logic [63:0] hi);
		lanes_t p;
		p[0] = 64'(MUL_K0) * 64'(hi[31:0]);
		p[1] = 64'(MUL_K1) * 64'(hi[63:32]);
		p[2] = 64'(MUL_K2) * 64'(lo[31:0]);
		p[3] = 64'(MUL_K3) * 64'(lo[63:32]);
		return p;
	endfunction

endpackage

// ===== hdl/shb_front.sv =====
// Front end of the block hash: takes stream items, pads partial blocks,
// multiplies by the lane constants and classifies. Depends on shb_pkg.
module shb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, rest zero
	input  logic [shb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            push,
	output shb_pkg::qent_t                  push_ent,
	input  logic                            full
);
	import shb_pkg::*;

	logic [COUNT_W-1:0]         cnt;
	logic [BLOCK_BYTES-1:0][7:0] raw;
	logic [BLOCK_BYTES-1:0][7:0] pad;
	logic                       has_block;
	logic                       keep;
	logic                       accept;
	logic                       vld_s1;
	qent_t                      ent_s1;

	// Clamp the count and pad the block past its length
	always_comb begin
		cnt = s_axis_tdata[128 +: COUNT_W];
		if (cnt[COUNT_W-1]) begin
			cnt = COUNT_W'(BLOCK_BYTES);
		end
		raw = s_axis_tdata[127:0];
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			if (COUNT_W'(k) < cnt) begin
				pad[k] = raw[k];
			end else if (COUNT_W'(k) == cnt) begin
				pad[k] = 8'(cnt);
			end else begin
				pad[k] = 8'h00;
			end
		end
	end

	// Classify: an empty item that does not finish the message is dropped here
	assign has_block = (cnt != '0);
	assign keep      = has_block | s_axis_tlast;

	assign s_axis_tready = !vld_s1 || !full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = vld_s1 && !full;
	assign push_ent      = ent_s1;

	// Stage 1 valid: advance whenever the stage empties into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= accept && keep;
		end
	end

	// Stage 1 payload: products of the padded block
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1.prod      <= mul_block(pad[7:0], pad[15:8]);
			ent_s1.has_block <= has_block;
			ent_s1.last      <= s_axis_tlast;
		end
	end

endmodule

// ===== hdl/shb_fifo.sv =====
// Short queue of classified items between the front and back of the block hash.
// Depends on shb_pkg for the entry type.
module shb_fifo #(
	parameter int unsigned DEPTH = shb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  shb_pkg::qent_t  wr_ent,
	output logic            full,
	input  logic            pop,
	output shb_pkg::qent_t  rd_ent,
	output logic            empty
);
	import shb_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	qent_t            ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_ent = ent_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_ent;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

// ===== hdl/shb_back.sv =====
// Back end of the block hash: sequences the state mix, finalization and the
// digest output register. Depends on shb_pkg.
module shb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  shb_pkg::qent_t                q_ent,
	output logic                          q_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [63:0] digest_word0, [127:64] digest_word1, [191:128] digest_word2,
	// [255:192] digest_word3
	output logic [shb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import shb_pkg::*;

	// Dword selections, entry k picks source dword sel[k]
	localparam logic [3:0][1:0] SEL_ROT_RIGHT = {2'd0, 2'd3, 2'd2, 2'd1};
	localparam logic [3:0][1:0] SEL_SWAP_MIX  = {2'd0, 2'd1, 2'd3, 2'd2};
	localparam logic [3:0][1:0] SEL_ROT_LEFT  = {2'd2, 2'd1, 2'd0, 2'd3};
	localparam logic [1:0]      PH_LAST       = 2'd3;

	back_st_t   st_q, st_d;
	logic [1:0] phase_q;
	logic       fin_pend_q;
	logic       final_q;
	lanes_t     prod_q;
	lanes_t     lanes_q;
	lanes_t     lanes_mix;
	lanes_t     out_q;
	logic       out_valid_q;
	logic       emit;
	logic       mix_end;
	half_t      h0, h1, t0, t1;

	function automatic half_t shuffle(input half_t v, input logic [3:0][1:0] sel);
		logic [3:0][31:0] d, r;
		d = v;
		for (int k = 0; k < 4; k++) begin
			r[k] = d[sel[k]];
		end
		return r;
	endfunction

	function automatic half_t sub_half(input half_t a, input half_t b);
		half_t r;
		r[0] = a[0] - b[0];
		r[1] = a[1] - b[1];
		return r;
	endfunction

	// Xor-shift, then add the half shifted left by two bytes
	function automatic half_t spread_a(input half_t v);
		logic [63:0] a, b;
		half_t       r;
		a = v[0] ^ (v[0] >> XS_FIRST);
		b = v[1] ^ (v[1] >> XS_FIRST);
		r[0] = a + (a << 16);
		r[1] = b + ((b << 16) | (a >> 48));
		return r;
	endfunction

	// Xor-shift, then add the half shifted left by four bytes
	function automatic half_t spread_b(input half_t v);
		logic [63:0] a, b;
		half_t       r;
		a = v[0] ^ (v[0] >> XS_SECOND);
		b = v[1] ^ (v[1] >> XS_SECOND);
		r[0] = a + (a << 32);
		r[1] = b + ((b << 32) | (a >> 32));
		return r;
	endfunction

	// One mix phase of the state, selected by the phase counter
	always_comb begin
		h0 = lanes_q[1:0];
		h1 = lanes_q[3:2];
		t0 = h0;
		t1 = h1;
		unique case (phase_q)
			2'd0: begin
				t0 = spread_a(sub_half(h0, prod_q[1:0]));
				t1 = spread_a(sub_half(h1, prod_q[3:2]));
			end
			2'd1: begin
				t1 = spread_b(h1);
				t0 = sub_half(spread_b(h0), t1);
			end
			2'd2: begin
				t1 = sub_half(shuffle(h1, SEL_ROT_RIGHT), h0);
				t0 = sub_half(shuffle(h0, SEL_SWAP_MIX), t1);
			end
			default: begin
				t1 = sub_half(shuffle(h1, SEL_ROT_LEFT), h0);
				t0 = sub_half(shuffle(h0, SEL_ROT_LEFT), t1);
			end
		endcase
		lanes_mix = {t1, t0};
	end

	assign mix_end = (st_q == B_MIX) && (phase_q == PH_LAST);

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					st_d = q_ent.has_block ? B_MIX : B_FMUL;
				end
			end
			B_MIX: begin
				if (phase_q == PH_LAST) begin
					if (final_q) begin
						st_d = B_EMIT;
					end else if (fin_pend_q) begin
						st_d = B_FMUL;
					end else if (!q_empty) begin
						st_d = q_ent.has_block ? B_MIX : B_FMUL;
					end else begin
						st_d = B_IDLE;
					end
				end
			end
			B_FMUL: begin
				st_d = B_MIX;
			end
			B_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					st_d = B_IDLE;
				end
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		unique case (st_q)
			B_IDLE: q_pop = !q_empty;
			B_MIX:  q_pop = !q_empty && mix_end && !final_q && !fin_pend_q;
			B_FMUL: q_pop = 1'b0;
			B_EMIT: emit  = !out_valid_q || m_axis_tready;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			phase_q     <= '0;
			fin_pend_q  <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			phase_q <= (st_q == B_MIX) ? phase_q + 2'd1 : 2'd0;
			if (q_pop) begin
				fin_pend_q <= q_ent.has_block && q_ent.last;
			end else if (st_q == B_FMUL) begin
				fin_pend_q <= 1'b0;
			end
			if (st_q == B_FMUL) begin
				final_q <= 1'b1;
			end else if (emit) begin
				final_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hash state: mix, reload the first half for finalization, restart after emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= INIT_LANES;
		end else if (st_q == B_MIX) begin
			lanes_q <= lanes_mix;
		end else if (st_q == B_FMUL) begin
			lanes_q[0] <= INIT_LO;
			lanes_q[1] <= INIT_HI;
		end else if (emit) begin
			lanes_q <= INIT_LANES;
		end
	end

	// Products of the block being mixed; finalization multiplies the first half
	always_ff @(posedge clk) begin
		if (q_pop && q_ent.has_block) begin
			prod_q <= q_ent.prod;
		end else if (st_q == B_FMUL) begin
			prod_q <= mul_block(lanes_q[0], lanes_q[1]);
		end
	end

	// Digest output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= lanes_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_phase_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != 2'd0) |-> (st_q == B_MIX))
		else $error("mix phase advanced outside the mix state");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (lanes_q == INIT_LANES) && m_axis_tvalid)
		else $error("state not restarted or digest not shown after emit");
	a_final_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(final_q && fin_pend_q))
		else $error("finalization pending during final mix");

endmodule

// ===== hdl/simd_block_hash_256.sv =====
// 256-bit block hash over a stream of 16-byte little-endian message blocks.
// Top level: front end, item queue and back end. Depends on shb_pkg.
//
// The input side takes one item per cycle as long as the item queue has room
// (QUEUE_DEPTH entries plus one front stage). A block is padded and multiplied
// in the front stage; the back end then mixes it into the hash state in the
// four phases of the state recurrence, which set the sustained rate for a
// stream of blocks. A final item (tlast) adds back-end work: multiplying the
// first state half, mixing it in four phases, then moving the digest into the
// output register. An item with zero valid bytes that is not final is dropped
// in the front and costs the back end nothing. The digest is held in an output
// register, so the back end keeps working on the next message while a digest
// waits to be taken, until it has another to emit.
module simd_block_hash_256 #(
	parameter int unsigned QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, rest zero
	input  logic [shb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// last
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [63:0] digest_word0, [127:64] digest_word1, [191:128] digest_word2,
	// [255:192] digest_word3
	output logic [shb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import shb_pkg::*;

	logic  fq_push;
	logic  fq_full;
	logic  fq_pop;
	logic  fq_empty;
	qent_t fq_wr_ent;
	qent_t fq_rd_ent;

	shb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push          (fq_push),
		.push_ent      (fq_wr_ent),
		.full          (fq_full)
	);

	shb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wr_ent (fq_wr_ent),
		.full   (fq_full),
		.pop    (fq_pop),
		.rd_ent (fq_rd_ent),
		.empty  (fq_empty)
	);

	shb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (fq_empty),
		.q_ent         (fq_rd_ent),
		.q_pop         (fq_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== bench/hash_digest_checker.sv =====
// Digest checker for the 256-bit block hash: watches both stream channels,
// predicts each digest from the accepted blocks and compares it on arrival.
// Depends on shb_pkg for the stream widths and lane types.
module hash_digest_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	// [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, rest zero
	input  logic [shb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// last
	input  logic                          s_axis_tlast,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [63:0] digest_word0, [127:64] digest_word1, [191:128] digest_word2,
	// [255:192] digest_word3
	input  logic [shb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output int                            fail_count,
	output int                            pending,
	output int                            digests_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import shb_pkg::*;

	localparam logic [63:0] START_LO    = 64'hC726_5595_564A_4447;
	localparam logic [63:0] START_HI    = 64'h128F_A608_E20C_241D;
	localparam lanes_t      START_LANES = {START_HI, START_LO, START_HI, START_LO};

	// Multipliers, zero-extended so the product keeps all 64 bits
	localparam logic [63:0] MULT0 = 64'h0000_0000_98B3_65A1;
	localparam logic [63:0] MULT1 = 64'h0000_0000_52C6_9CAB;
	localparam logic [63:0] MULT2 = 64'h0000_0000_B76A_9A41;
	localparam logic [63:0] MULT3 = 64'h0000_0000_CC4D_2C7B;

	// Dword selects, destination dword k takes source dword sel[2k+1:2k]
	localparam logic [7:0] ROT_RIGHT  = {2'd0, 2'd3, 2'd2, 2'd1};
	localparam logic [7:0] SWAP_MIXED = {2'd0, 2'd1, 2'd3, 2'd2};
	localparam logic [7:0] ROT_LEFT   = {2'd2, 2'd1, 2'd0, 2'd3};

	localparam int FULL_BLOCK = 16;
	localparam int SHOW_LIMIT = 100;

	// Xor-shift within lanes, then add the half shifted up by 2 and 4 bytes
	function automatic half_t spread_half(input half_t h);
		logic [63:0] a, b, sa, sb;
		a = h[0];
		b = h[1];
		a = a ^ (a >> 29);
		b = b ^ (b >> 29);
		sa = a << 16;
		sb = (b << 16) | (a >> 48);
		a = a + sa;
		b = b + sb;
		a = a ^ (a >> 21);
		b = b ^ (b >> 21);
		sa = a << 32;
		sb = (b << 32) | (a >> 32);
		a = a + sa;
		b = b + sb;
		return {b, a};
	endfunction

	// Permute the dwords of a half, then subtract another half lane by lane
	function automatic half_t shuffle_sub(input half_t h, input logic [7:0] sel,
			input half_t t);
		logic [127:0] src, dst;
		int k;
		src = h;
		for (k = 0; k < 4; k++) begin
			dst[32*k +: 32] = src[32*sel[2*k +: 2] +: 32];
		end
		return {dst[127:64] - t[1], dst[63:0] - t[0]};
	endfunction

	// Fold one 16-byte block into the four state lanes
	function automatic lanes_t mix_block(input lanes_t s, input logic [63:0] lo,
			input logic [63:0] hi);
		half_t h1, h2;
		s[0] = s[0] - MULT0 * {32'd0, hi[31:0]};
		s[1] = s[1] - MULT1 * {32'd0, hi[63:32]};
		s[2] = s[2] - MULT2 * {32'd0, lo[31:0]};
		s[3] = s[3] - MULT3 * {32'd0, lo[63:32]};
		h1 = spread_half({s[1], s[0]});
		h2 = spread_half({s[3], s[2]});
		h1[0] = h1[0] - h2[0];
		h1[1] = h1[1] - h2[1];
		h2 = shuffle_sub(h2, ROT_RIGHT, h1);
		h1 = shuffle_sub(h1, SWAP_MIXED, h2);
		h2 = shuffle_sub(h2, ROT_LEFT, h1);
		h1 = shuffle_sub(h1, ROT_LEFT, h2);
		return {h2, h1};
	endfunction

	lanes_t hash_lanes = START_LANES;
	lanes_t expected_digests[$];
	int     errors = 0;
	int     checked = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		logic [127:0] blk;
		logic [4:0]   n;
		logic [63:0]  fold_lo, fold_hi;
		lanes_t       digest, got;
		int           k;
		if (!arst_n) begin
			hash_lanes = START_LANES;
			expected_digests.delete();
		end else begin
			// Compare an outgoing digest first; a digest never leaves in the
			// cycle its final item goes in
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_digests.size() == 0) begin
					errors++;
					if (errors <= SHOW_LIMIT)
						$display("%0t: digest %h arrived with none expected", $time, got);
				end else begin
					digest = expected_digests.pop_front();
					checked++;
					for (k = 0; k < 4; k++) begin
						if (got[k] !== digest[k]) begin
							errors++;
							if (errors <= SHOW_LIMIT)
								$display("%0t: digest_word%0d expected %h got %h",
									$time, k, digest[k], got[k]);
						end
					end
				end
				if (errors > SHOW_LIMIT && errors - SHOW_LIMIT <= 4)
					$display("%0t: further mismatches counted but not shown", $time);
			end

			// Absorb an incoming transfer: pad a short block, mix, finalize
			if (s_axis_tvalid && s_axis_tready) begin
				blk = s_axis_tdata[127:0];
				n = s_axis_tdata[132:128];
				if (n > FULL_BLOCK)
					n = 5'(FULL_BLOCK);
				if (n != 0) begin
					for (k = 0; k < FULL_BLOCK; k++) begin
						if (k == n)
							blk[8*k +: 8] = 8'(n);
						else if (k > n)
							blk[8*k +: 8] = 8'd0;
					end
					hash_lanes = mix_block(hash_lanes, blk[63:0], blk[127:64]);
				end
				if (s_axis_tlast) begin
					fold_lo = hash_lanes[0];
					fold_hi = hash_lanes[1];
					digest = mix_block({hash_lanes[3], hash_lanes[2], START_HI, START_LO},
						fold_lo, fold_hi);
					expected_digests.push_back(digest);
					hash_lanes = START_LANES;
				end
			end
		end
		fail_count <= errors;
		pending <= expected_digests.size();
		digests_checked <= checked;
	end

endmodule

// ===== bench/simd_block_hash_256_test.sv =====
// Top of the block hash testbench: clock, reset, stream stimulus with random
// pacing on both sides, watchdog and verdict. Depends on shb_pkg, the hash
// block and hash_digest_checker.
module simd_block_hash_256_test;
	timeunit 1ns;
	timeprecision 1ps;
	import shb_pkg::*;

	localparam int ITEM_TARGET  = 1350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int FULL_BLOCK   = 16;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	int fail_count, pending, digests_checked;
	bit calm = 1'b0;
	int counted = 0;
	int blocks_sent = 0;
	int messages_sent = 0;
	int idle_cycles = 0;
	int rx_hold = 0;

	always #2 clk = ~clk;

	simd_block_hash_256 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	hash_digest_checker digest_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.fail_count     (fail_count),
		.pending        (pending),
		.digests_checked(digests_checked)
	);

	// Mostly no gap, often a short one, rarely a long one; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one item after a random gap and hold it until the transfer
	task automatic send_item(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] vb, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, vb, hi, lo};
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (vb != 0 || fin)
			counted++;
		if (vb != 0)
			blocks_sent++;
		if (fin)
			messages_sent++;
		@(negedge clk);
	endtask

	// Stall the digest side at random
	always @(negedge clk) begin : rx_pace
		int len;
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			len = pick_gap();
			if (len > 0) begin
				rx_hold = len - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// End the run if no transfer happens on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("simd_block_hash_256_test: FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int          n, len, i, r, d;
		logic [4:0]  vb;
		logic [63:0] lo, hi;
		logic        fin;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extreme data in full blocks
		send_item('0, '0, 5'd16, 1'b0);
		send_item('1, '1, 5'd16, 1'b1);
		// Empty message: finalize only
		send_item('0, '0, 5'd0, 1'b1);
		// Empty item that is not last is dropped, so this repeats the digest above
		send_item('1, '1, 5'd0, 1'b0);
		send_item('1, '1, 5'd0, 1'b1);
		// Every partial length, some closing a message and some mid-stream
		for (n = 1; n < FULL_BLOCK; n++)
			send_item('1, '1, 5'(n), (n % 3) == 0);
		// Oversized counts act as full blocks
		send_item('1, '1, 5'd17, 1'b0);
		send_item('1, '1, 5'd31, 1'b1);

		// Random messages, mostly short, now and then a long one
		while (counted < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				calm = ~calm;
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
			for (i = 0; i < len; i++) begin
				fin = (i == len - 1);
				r = $urandom_range(0, 99);
				if (r < (fin ? 45 : 75))
					vb = 5'd16;
				else if (r < (fin ? 80 : 88))
					vb = 5'($urandom_range(1, 15));
				else if (r < (fin ? 90 : 94))
					vb = 5'($urandom_range(17, 31));
				else
					vb = 5'd0;
				d = $urandom_range(0, 31);
				lo = (d == 0) ? '0 : (d == 1) ? '1 : {$urandom, $urandom};
				d = $urandom_range(0, 31);
				hi = (d == 0) ? '0 : (d == 1) ? '1 : {$urandom, $urandom};
				send_item(lo, hi, vb, fin);
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain outstanding digests, then give the block time to misbehave
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items: %0d blocks in %0d messages, lengths 0..31,",
			counted, blocks_sent, messages_sent);
		$display("random stalls on both channels; %0d digests compared.", digests_checked);
		if (fail_count == 0)
			$display("simd_block_hash_256_test: PASS");
		else
			$display("simd_block_hash_256_test: FAIL");
		$finish;
	end

endmodule

// ===== simd_block_hash_256.f =====
hdl/shb_pkg.sv
hdl/shb_front.sv
hdl/shb_fifo.sv
hdl/shb_back.sv
hdl/simd_block_hash_256.sv
bench/hash_digest_checker.sv
bench/simd_block_hash_256_test.sv
